/* rtl/mbld_pkg.sv */
// Shared types and constants for the button lockout debouncer.
package mbld_pkg;

    localparam int PORT_COUNT  = 4;
    localparam int PORT_PINS   = 8;
    localparam int EVENT_W     = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [7:0] HOLD_RESET  = 8'd10;
    localparam logic [7:0] LEVEL_RESET = 8'hFF;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    localparam logic [CFG_INDEX_W-1:0] REG_PIN_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS = 2'd1;

endpackage

/* rtl/multi_button_lockout_debouncer_core.sv */
// Top level: input register, per-pin debounce and lockout logic, result register.
// A read beat passes the input register, then its result is held in the result register.
// One item per cycle while the result register is free; samples and ticks may still enter
// while a read result waits to be taken, but a read beat then waits in the input register.
// Reset clears all button state, latched events and lockouts at once; port levels reset
// to all ones, pin_enable to zero and hold_ticks to ten.
module multi_button_lockout_debouncer_core
    import mbld_pkg::*;
#(
    parameter int PIN_SLOTS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             op,
    input  logic [1:0]             port,
    input  logic [7:0]             pin_levels,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [EVENT_W-1:0]     press_events
);

    // Only the first 32 slots can be reached by a port and pin.
    localparam int ACTIVE_SLOTS = (PIN_SLOTS < EVENT_W) ? PIN_SLOTS : EVENT_W;

    logic [31:0]             pin_enable_reg;
    logic [7:0]              hold_ticks_reg;

    logic                    stage_valid_reg;
    logic [1:0]              op_reg;
    logic [1:0]              port_reg;
    logic [7:0]              levels_reg;

    logic [7:0]              level_reg     [PORT_COUNT];
    logic [7:0]              level_next    [PORT_COUNT];
    logic [7:0]              lockout_reg   [ACTIVE_SLOTS];
    logic [7:0]              lockout_next  [ACTIVE_SLOTS];
    logic [ACTIVE_SLOTS-1:0] pressed_reg;
    logic [ACTIVE_SLOTS-1:0] pressed_next;
    logic [ACTIVE_SLOTS-1:0] latched_reg;
    logic [ACTIVE_SLOTS-1:0] latched_next;

    logic                    out_valid_reg;
    logic [EVENT_W-1:0]      events_reg;
    logic [EVENT_W-1:0]      events_next;

    logic                    is_read;
    logic                    advance;
    logic                    process;
    logic [7:0]              diff;

    assign is_read  = (op_reg == OP_READ);
    // A read beat may only leave the stage when the result register is free.
    assign advance  = !stage_valid_reg || !is_read || !out_valid_reg || out_ready;
    assign process  = stage_valid_reg && advance;
    assign in_ready = advance;

    assign out_valid    = out_valid_reg;
    assign press_events = events_reg;

    assign diff = levels_reg ^ level_reg[port_reg];

    always_comb
    begin
        for (int p = 0; p < PORT_COUNT; p++)
        begin
            level_next[p] = level_reg[p];
        end
        for (int s = 0; s < ACTIVE_SLOTS; s++)
        begin
            lockout_next[s] = lockout_reg[s];
        end
        pressed_next = pressed_reg;
        latched_next = latched_reg;
        events_next  = '0;

        unique case (op_reg)
            OP_SAMPLE:
            begin
                level_next[port_reg] = levels_reg;
                for (int s = 0; s < ACTIVE_SLOTS; s++)
                begin
                    if ((s / PORT_PINS) == int'(port_reg) && diff[s % PORT_PINS]
                        && pin_enable_reg[s] && lockout_reg[s] == 8'd0)
                    begin
                        if (!levels_reg[s % PORT_PINS] && !pressed_reg[s])
                        begin
                            pressed_next[s] = 1'b1;
                            latched_next[s] = 1'b1;
                            lockout_next[s] = hold_ticks_reg;
                        end
                        else if (levels_reg[s % PORT_PINS] && pressed_reg[s])
                        begin
                            pressed_next[s] = 1'b0;
                            lockout_next[s] = hold_ticks_reg;
                        end
                    end
                end
            end
            OP_TICK:
            begin
                for (int s = 0; s < ACTIVE_SLOTS; s++)
                begin
                    if (lockout_reg[s] != 8'd0)
                    begin
                        lockout_next[s] = lockout_reg[s] - 8'd1;
                    end
                end
            end
            OP_READ:
            begin
                events_next[ACTIVE_SLOTS-1:0] = latched_reg;
                latched_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_enable_reg  <= '0;
            hold_ticks_reg  <= HOLD_RESET;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            pressed_reg     <= '0;
            latched_reg     <= '0;
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                level_reg[p] <= LEVEL_RESET;
            end
            for (int s = 0; s < ACTIVE_SLOTS; s++)
            begin
                lockout_reg[s] <= 8'd0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_PIN_ENABLE)
                begin
                    pin_enable_reg <= cfg_data;
                end
                else if (cfg_index == REG_HOLD_TICKS)
                begin
                    hold_ticks_reg <= cfg_data[7:0];
                end
            end

            if (advance)
            begin
                stage_valid_reg <= in_valid;
            end

            if (process)
            begin
                pressed_reg <= pressed_next;
                latched_reg <= latched_next;
                for (int p = 0; p < PORT_COUNT; p++)
                begin
                    level_reg[p] <= level_next[p];
                end
                for (int s = 0; s < ACTIVE_SLOTS; s++)
                begin
                    lockout_reg[s] <= lockout_next[s];
                end
            end

            if (process && is_read)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            op_reg     <= op;
            port_reg   <= port;
            levels_reg <= pin_levels;
        end
        if (process && is_read)
        begin
            events_reg <= events_next;
        end
    end

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the multi-button lockout debouncer core.
`timescale 1ns / 1ps

module tb_top;
    import mbld_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int DRAIN_CYCLES = 6;
    localparam int STALL_CYCLES = 300;
    localparam int IDLE_LIMIT = 4000;
    localparam int REPORT_MAX = 10;

    // Tracks button state the way the block should and holds the read results still owed.
    class debounce_tracker;
        logic [31:0]        pin_enable;
        logic [7:0]         hold_ticks;
        logic [7:0]         port_level [PORT_COUNT];
        logic [7:0]         lockout [32];
        bit                 pressed [32];
        bit                 latched [32];
        logic [EVENT_W-1:0] events_due [$];
        int                 bad_count;

        function new();
            pin_enable = '0;
            hold_ticks = HOLD_RESET;
            foreach (port_level[i])
                port_level[i] = LEVEL_RESET;
            foreach (lockout[i])
            begin
                lockout[i] = '0;
                pressed[i] = 1'b0;
                latched[i] = 1'b0;
            end
            bad_count = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PIN_ENABLE: pin_enable = data;
                REG_HOLD_TICKS: hold_ticks = data[7:0];
                default: ;
            endcase
        endfunction

        function void accept_beat(logic [1:0] code, logic [1:0] which, logic [7:0] levels);
            logic [7:0]         diff;
            int                 slot;
            logic [EVENT_W-1:0] events;
            case (op_t'(code))
                OP_SAMPLE:
                begin
                    diff = levels ^ port_level[which];
                    for (int pin = 0; pin < PORT_PINS; pin++)
                    begin
                        slot = int'(which) * PORT_PINS + pin;
                        if (diff[pin] && pin_enable[slot] && lockout[slot] == 8'd0)
                        begin
                            if (!levels[pin] && !pressed[slot])
                            begin
                                pressed[slot] = 1'b1;
                                latched[slot] = 1'b1;
                                lockout[slot] = hold_ticks;
                            end
                            else if (levels[pin] && pressed[slot])
                            begin
                                pressed[slot] = 1'b0;
                                lockout[slot] = hold_ticks;
                            end
                        end
                    end
                    // The stored level follows the sample even when a change was lost.
                    port_level[which] = levels;
                end
                OP_TICK:
                begin
                    foreach (lockout[i])
                        if (lockout[i] != 8'd0)
                            lockout[i] = lockout[i] - 8'd1;
                end
                OP_READ:
                begin
                    events = '0;
                    foreach (latched[i])
                    begin
                        events[i] = latched[i];
                        latched[i] = 1'b0;
                    end
                    events_due.push_back(events);
                end
                default: ;
            endcase
        endfunction

        function void compare_events(logic [EVENT_W-1:0] actual);
            logic [EVENT_W-1:0] want;
            if (events_due.size() == 0)
            begin
                if (bad_count < REPORT_MAX)
                    $display("unexpected result beat: press_events %08h, nothing pending",
                             actual);
                bad_count++;
            end
            else
            begin
                want = events_due.pop_front();
                if (actual !== want)
                begin
                    if (bad_count < REPORT_MAX)
                        $display("press_events mismatch: expected %08h, got %08h",
                                 want, actual);
                    bad_count++;
                end
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             op;
    logic [1:0]             port;
    logic [7:0]             pin_levels;
    logic                   out_valid;
    logic                   out_ready;
    logic [EVENT_W-1:0]     press_events;

    debounce_tracker tracker = new();
    logic [7:0]      sent_level [PORT_COUNT];
    bit              stall_request = 1'b0;
    int              idle_cycles = 0;
    bit              moved;

    multi_button_lockout_debouncer_core dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Both handshakes are seen here at the rising edge; the watchdog rides along.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (out_valid && out_ready)
            begin
                tracker.compare_events(press_events);
                moved = 1'b1;
            end
            if (in_valid && in_ready)
            begin
                tracker.accept_beat(op, port, pin_levels);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver: random ready with gaps, plus one long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (stall_request)
            begin
                @(negedge clk) out_ready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge clk);
                stall_request = 1'b0;
            end
            else
            begin
                @(negedge clk) out_ready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge clk);
                begin
                    int gap;
                    gap = pick_gap();
                    if (gap > 0)
                    begin
                        @(negedge clk) out_ready <= 1'b0;
                        repeat (gap - 1) @(negedge clk);
                    end
                end
            end
        end
    end

    // Valid stays high between back-to-back beats; it only drops for a gap.
    task automatic offer_item(logic [1:0] code, logic [1:0] which, logic [7:0] levels);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        op         <= code;
        port       <= which;
        pin_levels <= levels;
        if (code == OP_SAMPLE)
            sent_level[which] = levels;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
        @(negedge clk) cfg_write <= 1'b0;
    endtask

    // Samples and ticks leave nothing to wait for, so pause past the pipeline depth too.
    task automatic drain_block();
        @(negedge clk) in_valid <= 1'b0;
        while (tracker.events_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic directed_items();
        logic [31:0] cfg_word;
        // Reset settings: no pin enabled, so nothing can latch.
        offer_item(OP_SAMPLE, 2'd0, 8'h00);
        offer_item(OP_READ, 2'd0, 8'h00);
        drain_block();
        write_reg(REG_PIN_ENABLE, 32'hFFFF_FFFF);
        cfg_word = $urandom;
        cfg_word[7:0] = 8'd2;
        write_reg(REG_HOLD_TICKS, cfg_word);
        offer_item(OP_SAMPLE, 2'd0, 8'hFF);
        offer_item(OP_SAMPLE, 2'd0, 8'h00);
        offer_item(OP_SAMPLE, 2'd3, 8'h7F);
        offer_item(OP_READ, 2'd3, 8'hFF);
        // Release during the lockout is lost, and the stored level still moves.
        offer_item(OP_SAMPLE, 2'd0, 8'hFF);
        offer_item(OP_TICK, 2'd0, 8'h00);
        offer_item(OP_TICK, 2'd0, 8'h00);
        offer_item(OP_SAMPLE, 2'd0, 8'h00);
        offer_item(OP_SAMPLE, 2'd0, 8'hFF);
        offer_item(OP_TICK, 2'd1, 8'h00);
        offer_item(OP_TICK, 2'd2, 8'hFF);
        offer_item(OP_TICK, 2'd3, 8'h00);
        offer_item(OP_SAMPLE, 2'd0, 8'h00);
        offer_item(OP_UNUSED, 2'd3, 8'hFF);
        offer_item(OP_READ, 2'd0, 8'h00);
        offer_item(OP_READ, 2'd0, 8'h00);
        offer_item(OP_SAMPLE, 2'd1, 8'h55);
        offer_item(OP_SAMPLE, 2'd2, 8'hAA);
        offer_item(OP_TICK, 2'd0, 8'h00);
        offer_item(OP_SAMPLE, 2'd3, 8'hFF);
        offer_item(OP_READ, 2'd1, 8'h00);
    endtask

    task automatic run_phase(logic [31:0] enable, logic [7:0] hold, int count,
                             int tick_pct, int stall_at);
        logic [31:0] cfg_word;
        logic [1:0]  code;
        logic [1:0]  which;
        logic [7:0]  levels;
        int          r;
        drain_block();
        write_reg(REG_PIN_ENABLE, enable);
        cfg_word = $urandom;
        cfg_word[7:0] = hold;
        write_reg(REG_HOLD_TICKS, cfg_word);
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        for (int i = 0; i < count; i++)
        begin
            if (i == stall_at)
                stall_request = 1'b1;
            r = $urandom_range(0, 99);
            which = 2'($urandom_range(0, 3));
            levels = 8'($urandom);
            if (r < 3)
                code = OP_UNUSED;
            else if (r < 13)
                code = OP_READ;
            else if (r < 13 + tick_pct)
                code = OP_TICK;
            else
            begin
                code = OP_SAMPLE;
                // Mostly flip one or two pins so presses and releases pair up.
                if ($urandom_range(0, 4) != 0)
                begin
                    levels = sent_level[which] ^ (8'd1 << $urandom_range(0, 7));
                    if ($urandom_range(0, 2) == 0)
                        levels = levels ^ (8'd1 << $urandom_range(0, 7));
                end
            end
            offer_item(code, which, levels);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        op         = '0;
        port       = '0;
        pin_levels = '0;
        foreach (sent_level[i])
            sent_level[i] = LEVEL_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        directed_items();
        run_phase(32'hFFFF_FFFF, 8'd0, 200, 35, -1);
        run_phase($urandom, 8'd1, 250, 35, 120);
        run_phase(32'hFFFF_FFFF, 8'd255, 400, 70, -1);
        run_phase(32'h0000_0000, 8'd3, 100, 35, -1);
        run_phase($urandom, 8'($urandom_range(0, 7)), 300, 40, -1);
        run_phase(32'hFFFF_FFFF, 8'($urandom_range(0, 255)), 300, 50, -1);
        drain_block();

        if (tracker.bad_count == 0 && tracker.events_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
